// ===== hw/rtl/u2u_pkg.sv =====
package u2u_pkg;

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;
  localparam logic [7:0] LEAD5_MASK = 8'hFC;
  localparam logic [7:0] LEAD5_TAG  = 8'hF8;
  localparam logic [7:0] LEAD6_MASK = 8'hFE;
  localparam logic [7:0] LEAD6_TAG  = 8'hFC;

  localparam logic [15:0] SUBST_UNIT = 16'h003F;

  localparam logic [2:0] SKIP_LEAD4 = 3'd3;
  localparam logic [2:0] SKIP_LEAD5 = 3'd4;
  localparam logic [2:0] SKIP_LEAD6 = 3'd5;

  localparam int MAX_UNITS = 3;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TWO_LAST,
    PH_THREE_MID,
    PH_THREE_LAST
  } phase_t;

  typedef logic [1:0] cnt_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        replaced;
    logic        unit_present;
    logic        last_of_run;
  } unit_t;

  typedef struct packed {
    logic                        load;
    cnt_t                        count;
    unit_t [MAX_UNITS-1:0]       units;
  } bundle_t;

endpackage

// ===== hw/rtl/u2u_in_if.sv =====
interface u2u_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

// ===== hw/rtl/u2u_out_if.sv =====
interface u2u_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        replaced;
  logic        unit_present;
  logic        last_of_run;

  modport source (output valid, output code_unit, output replaced, output unit_present,
                  output last_of_run, input ready);
  modport sink   (input valid, input code_unit, input replaced, input unit_present,
                  input last_of_run, output ready);
endinterface

// ===== hw/rtl/utf8_to_ucs2_stream_decoder_core.sv =====
// UTF-8 to UCS-2 stream decoder.
// in_ch  : one UTF-8 byte per word, end_of_string set on the last byte of a string.
// out_ch : one 16-bit code unit per word, with replaced ('?' substitute), unit_present
//          (clear only on a bare end marker) and last_of_run (last word of a string).
// Both channels move a word on a clock edge with valid and ready high.
// Path: a byte accepted on in_ch is held in the input register, decoded, and its words
// are written into the result register, from which out_ch presents them.
// Throughput: one byte per cycle when each byte yields at most one word and out_ch
// does not stall. A byte that yields two or three words (error bursts, truncated
// sequences) holds the decode stage until out_ch takes its words; bytes that yield
// nothing (leads, continuations, skipped bytes) still pass through the decode stage.
// An input register and a three-entry result register part the two sides, so a
// byte is taken while a finished word waits. When out_ch stalls, words are held
// and in_ch ready drops once both the input and result registers hold data.
// Reset (rst_n low, synchronous) empties both registers and returns the decoder
// to idle with no sequence pending and no bytes left to skip.
module utf8_to_ucs2_stream_decoder_core
  import u2u_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  u2u_in_if.sink    in_ch,
  u2u_out_if.source out_ch
);

  bundle_t bundle;
  logic    buf_free;
  unit_t   out_unit;

  u2u_decode u_decode (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_data_byte     (in_ch.data_byte),
    .in_end_of_string (in_ch.end_of_string),
    .buf_free         (buf_free),
    .bundle           (bundle)
  );

  u2u_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .bundle    (bundle),
    .buf_free  (buf_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_unit  (out_unit)
  );

  assign out_ch.code_unit    = out_unit.code_unit;
  assign out_ch.replaced     = out_unit.replaced;
  assign out_ch.unit_present = out_unit.unit_present;
  assign out_ch.last_of_run  = out_unit.last_of_run;

endmodule

// ===== hw/rtl/u2u_decode.sv =====
module u2u_decode
  import u2u_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_string,
  input  logic        buf_free,
  output bundle_t     bundle
);

  logic       v_r;
  logic [7:0] byte_r;
  logic       eos_r;

  phase_t     phase_r, phase_nxt;
  logic [9:0] part_r, part_nxt;
  logic [2:0] skip_r, skip_nxt;

  logic        advance;
  logic        cont;
  logic        take;
  logic [1:0]  pre;
  logic        tail_v;
  unit_t       tail;
  logic [15:0] joined;
  cnt_t        count;

  assign advance  = v_r && buf_free;
  assign in_ready = !v_r || buf_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      v_r <= 1'b1;
    end else if (advance) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_data_byte;
      eos_r  <= in_end_of_string;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      part_r  <= '0;
      skip_r  <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      part_r  <= part_nxt;
      skip_r  <= skip_nxt;
    end
  end

  assign cont   = (byte_r & CONT_MASK) == CONT_TAG;
  assign joined = {part_r, byte_r[5:0]};

  always_comb begin
    phase_nxt = phase_r;
    part_nxt  = part_r;
    skip_nxt  = skip_r;
    pre       = 2'd0;
    take      = 1'b0;
    tail_v    = 1'b0;
    tail      = '0;

    if (skip_r != 3'd0) begin
      skip_nxt = skip_r - 3'd1;
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          take = 1'b1;
        end
        PH_TWO_LAST, PH_THREE_LAST: begin
          if (cont) begin
            phase_nxt = PH_IDLE;
            if (joined != 16'd0) begin
              tail_v            = 1'b1;
              tail.code_unit    = joined;
              tail.unit_present = 1'b1;
            end
          end else begin
            pre  = (phase_r == PH_TWO_LAST) ? 2'd1 : 2'd2;
            take = 1'b1;
          end
        end
        PH_THREE_MID: begin
          if (cont) begin
            part_nxt  = {part_r[3:0], byte_r[5:0]};
            phase_nxt = PH_THREE_LAST;
            if (eos_r) begin
              pre = 2'd2;
            end
          end else begin
            pre  = 2'd1;
            take = 1'b1;
          end
        end
        default: begin
          take = 1'b1;
        end
      endcase
    end

    // byte taken as a lead
    if (take) begin
      phase_nxt = PH_IDLE;
      priority if (!byte_r[7]) begin
        if (byte_r != 8'd0) begin
          tail_v            = 1'b1;
          tail.code_unit    = {8'd0, byte_r};
          tail.unit_present = 1'b1;
        end
      end else if ((byte_r & LEAD2_MASK) == LEAD2_TAG) begin
        if (eos_r) begin
          tail_v = 1'b1;
        end else begin
          phase_nxt = PH_TWO_LAST;
          part_nxt  = {5'd0, byte_r[4:0]};
        end
      end else if ((byte_r & LEAD3_MASK) == LEAD3_TAG) begin
        if (eos_r) begin
          tail_v = 1'b1;
        end else begin
          phase_nxt = PH_THREE_MID;
          part_nxt  = {6'd0, byte_r[3:0]};
        end
      end else if ((byte_r & LEAD4_MASK) == LEAD4_TAG) begin
        tail_v   = 1'b1;
        skip_nxt = SKIP_LEAD4;
      end else if ((byte_r & LEAD5_MASK) == LEAD5_TAG) begin
        tail_v   = 1'b1;
        skip_nxt = SKIP_LEAD5;
      end else if ((byte_r & LEAD6_MASK) == LEAD6_TAG) begin
        tail_v   = 1'b1;
        skip_nxt = SKIP_LEAD6;
      end else begin
        tail_v = 1'b1;
      end
      if (tail_v && !tail.unit_present) begin
        tail.code_unit    = SUBST_UNIT;
        tail.replaced     = 1'b1;
        tail.unit_present = 1'b1;
      end
    end

    // end of string: bare marker if nothing else, state back to idle
    if (eos_r) begin
      if (pre == 2'd0 && !tail_v) begin
        tail_v = 1'b1;
        tail   = '0;
      end
      phase_nxt = PH_IDLE;
      part_nxt  = '0;
      skip_nxt  = '0;
    end
  end

  assign count = pre + {1'b0, tail_v};

  always_comb begin
    bundle.load  = advance;
    bundle.count = count;
    for (int i = 0; i < MAX_UNITS; i++) begin
      if (pre > 2'(i)) begin
        bundle.units[i].code_unit    = SUBST_UNIT;
        bundle.units[i].replaced     = 1'b1;
        bundle.units[i].unit_present = 1'b1;
      end else begin
        bundle.units[i].code_unit    = tail.code_unit;
        bundle.units[i].replaced     = tail.replaced;
        bundle.units[i].unit_present = tail.unit_present;
      end
      bundle.units[i].last_of_run = eos_r && (count == 2'(i + 1));
    end
  end

endmodule

// ===== hw/rtl/u2u_outbuf.sv =====
module u2u_outbuf
  import u2u_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  bundle_t      bundle,
  output logic         buf_free,
  output logic         out_valid,
  input  logic         out_ready,
  output unit_t        out_unit
);

  unit_t [MAX_UNITS-1:0] units_r, units_nxt;
  cnt_t                  cnt_r, cnt_nxt;
  logic                  pop;

  assign out_valid = cnt_r != 2'd0;
  assign pop       = out_valid && out_ready;
  assign buf_free  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);
  assign out_unit  = units_r[0];

  always_comb begin
    units_nxt = units_r;
    cnt_nxt   = cnt_r;
    if (bundle.load) begin
      units_nxt = bundle.units;
      cnt_nxt   = bundle.count;
    end else if (pop) begin
      for (int i = 0; i < MAX_UNITS - 1; i++) begin
        units_nxt[i] = units_r[i + 1];
      end
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    units_r <= units_nxt;
  end

endmodule
